// ===== hdl/l2wcc_pkg.sv =====
// shared types, class codes and byte tables for the latin2 word case classifier
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps

package l2wcc_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned CLASS_W = 3;
  localparam int unsigned TDATA_W = 8;

  // case class codes on the result
  localparam logic [CLASS_W-1:0] CLASS_LOWER = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_CAP   = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_UPPER = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_MIXED = 3'd3;
  localparam logic [CLASS_W-1:0] CLASS_NUM   = 3'd4;
  localparam logic [CLASS_W-1:0] CLASS_UNDEF = 3'd5;

  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic upper;
    logic lower;
    logic digit;
    logic dot;
    logic minus;
  } char_class_t;

  function automatic logic is_upper(input logic [CHAR_W-1:0] b);
    logic r;
    r = 1'b0;
    case (b) inside
      [8'h41:8'h5A]: r = 1'b1;
      8'hA1, 8'hA3, 8'hA5, 8'hA6, 8'hA9, 8'hAA, 8'hAB, 8'hAC, 8'hAE, 8'hAF: r = 1'b1;
      [8'hC0:8'hD6], [8'hD8:8'hDF]: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // 0xdf is both cases; 0xa7, 0xd7 and 0xf7 count as lower
  function automatic logic is_lower(input logic [CHAR_W-1:0] b);
    logic r;
    r = 1'b0;
    case (b) inside
      [8'h61:8'h7A]: r = 1'b1;
      8'hB1, 8'hB3, 8'hB5, 8'hB6, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBE, 8'hBF: r = 1'b1;
      [8'hE0:8'hFE]: r = 1'b1;
      8'hA7, 8'hD7, 8'hDF: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // idx = {first_is_upper, all_upper_so_far, has_digit, all_numeric}
  function automatic logic [CLASS_W-1:0] class_lookup(input logic [3:0] idx,
                                                       input logic later_upper,
                                                       input logic one_char);
    logic [CLASS_W-1:0] r;
    r = CLASS_UNDEF;
    case (idx)
      4'd0:  r = later_upper ? CLASS_MIXED : CLASS_LOWER;
      4'd8:  r = later_upper ? CLASS_MIXED : CLASS_CAP;
      4'd12: r = one_char ? CLASS_CAP : CLASS_UPPER;
      4'd1, 4'd2, 4'd5, 4'd6, 4'd10, 4'd14: r = CLASS_MIXED;
      4'd7:  r = CLASS_NUM;
      default: r = CLASS_UNDEF;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/l2wcc_char_class.sv =====
// byte classifier: sorts one iso 8859-2 byte into upper, lower, digit, dot, minus
// depends on l2wcc_pkg
`timescale 1ns / 1ps

module l2wcc_char_class (
  input  logic [l2wcc_pkg::CHAR_W-1:0] char_code,
  output l2wcc_pkg::char_class_t       char_class
);

  always_comb begin
    char_class.upper = l2wcc_pkg::is_upper(char_code);
    char_class.lower = l2wcc_pkg::is_lower(char_code);
    char_class.digit = (char_code >= 8'h30) && (char_code <= 8'h39);
    char_class.dot   = (char_code == l2wcc_pkg::CHAR_DOT);
    char_class.minus = (char_code == l2wcc_pkg::CHAR_MINUS);
  end

endmodule

// ===== hdl/l2wcc_word_flags.sv =====
// running word flags and the case class they give on the last byte
// depends on l2wcc_pkg
`timescale 1ns / 1ps

module l2wcc_word_flags (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          char_last,
  input  l2wcc_pkg::char_class_t        char_class,
  output logic [l2wcc_pkg::CLASS_W-1:0] case_class
);

  logic at_word_start, first_is_upper, all_upper_so_far, has_digit;
  logic all_numeric, dot_seen, later_upper;
  logic first_is_upper_next, all_upper_so_far_next, has_digit_next;
  logic all_numeric_next, dot_seen_next, later_upper_next;

  always_comb begin
    first_is_upper_next   = at_word_start ? char_class.upper : first_is_upper;
    all_upper_so_far_next = all_upper_so_far & ~char_class.lower;
    later_upper_next      = later_upper | (char_class.upper & ~at_word_start);
    has_digit_next        = has_digit | char_class.digit;
    all_numeric_next      = all_numeric;
    dot_seen_next         = dot_seen;
    if (char_class.digit) begin
      all_numeric_next = all_numeric;
    end else if (char_class.dot) begin
      // only one dot allowed in a number
      if (dot_seen) all_numeric_next = 1'b0;
      else          dot_seen_next    = 1'b1;
    end else if (char_class.minus) begin
      // minus only as a leading sign
      if (!at_word_start) all_numeric_next = 1'b0;
    end else begin
      all_numeric_next = 1'b0;
    end
    case_class = l2wcc_pkg::class_lookup({first_is_upper_next, all_upper_so_far_next,
                                          has_digit_next, all_numeric_next},
                                         later_upper_next, at_word_start);
  end

  always_ff @(posedge clk) begin
    if (rst || (step && char_last)) begin
      at_word_start    <= 1'b1;
      first_is_upper   <= 1'b0;
      all_upper_so_far <= 1'b1;
      has_digit        <= 1'b0;
      all_numeric      <= 1'b1;
      dot_seen         <= 1'b0;
      later_upper      <= 1'b0;
    end else if (step) begin
      at_word_start    <= 1'b0;
      first_is_upper   <= first_is_upper_next;
      all_upper_so_far <= all_upper_so_far_next;
      has_digit        <= has_digit_next;
      all_numeric      <= all_numeric_next;
      dot_seen         <= dot_seen_next;
      later_upper      <= later_upper_next;
    end
  end

endmodule

// ===== hdl/latin2_word_case_classifier_core.sv =====
// top level of the latin2 word case classifier: input register, flag logic, result register
// depends on l2wcc_pkg, l2wcc_char_class and l2wcc_word_flags
`timescale 1ns / 1ps

// Takes the bytes of one ISO 8859-2 word, one request per byte, with tlast on the
// final byte, and returns one case class per word (0 lower, 1 capitalized, 2 upper,
// 3 mixed, 4 numeric, 5 undefined) on the master side. Bytes that are not last give
// no result. One byte is taken every cycle unless the slave side stalls; the class of
// a word enters the result register when its last byte leaves the input register. The
// input register feeds the byte classifier and the flag update, and the result register
// holds a finished class while the next word streams in; the slave side only stalls
// when a last byte is ready while the previous class still waits in the result register.
module latin2_word_case_classifier_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [l2wcc_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] char_code
  input  logic                           s_tlast,   // last_char
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [l2wcc_pkg::TDATA_W-1:0]  m_tdata    // [2:0] case_class, [7:3] zero
);

  // input register
  logic                          in_valid;
  logic [l2wcc_pkg::CHAR_W-1:0]  in_code;
  logic                          in_last;

  // result register
  logic [l2wcc_pkg::CLASS_W-1:0] case_class;
  logic [l2wcc_pkg::CLASS_W-1:0] case_class_next;

  l2wcc_pkg::char_class_t char_class;
  logic                   advance;

  // the held byte moves on unless it ends a word and the result slot is still full
  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  l2wcc_char_class u_char_class (
    .char_code  (in_code),
    .char_class (char_class)
  );

  l2wcc_word_flags u_word_flags (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .char_last  (in_last),
    .char_class (char_class),
    .case_class (case_class_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_code <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      case_class <= case_class_next;
    end
  end

  assign m_tdata = {{(l2wcc_pkg::TDATA_W - l2wcc_pkg::CLASS_W){1'b0}}, case_class};

endmodule

// ===== hdl/l2wcc_checker.sv =====
// port-level checks for the latin2 word case classifier, bound to the top level
// depends on l2wcc_pkg and latin2_word_case_classifier_core
`timescale 1ns / 1ps

module l2wcc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [l2wcc_pkg::TDATA_W-1:0] m_tdata
);

  // no result comes out right after reset
  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // class code in range and padding zero
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= l2wcc_pkg::CLASS_UNDEF) && (m_tdata[7:3] == 5'd0))
    else $error("case class out of range");

  // input only stalls behind a result that is not taken
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a pending result");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind latin2_word_case_classifier_core l2wcc_checker u_l2wcc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== test/tb_latin2_word_case_classifier_core.sv =====
// self-checking testbench for latin2_word_case_classifier_core: directed words, then random words
// depends on l2wcc_pkg and the core; a local flag tracker predicts the class of untyped words
`timescale 1ns / 1ps

module tb_latin2_word_case_classifier_core;

  localparam int RANDOM_CHARS = 1800;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_EVERY  = 450;   // sender holds off until all classes are back
  localparam int DIRECTED_N   = 24;

  // one directed request: byte, last flag, and a hand-typed class where obvious
  typedef struct packed {
    logic [l2wcc_pkg::CHAR_W-1:0]  code;
    logic                          last;
    logic                          typed;
    logic [l2wcc_pkg::CLASS_W-1:0] cls;
  } dir_row_t;

  // running flags of the word being received
  typedef struct packed {
    logic at_start;
    logic first_up;
    logic all_up;
    logic digit_seen;
    logic numeric;
    logic dot_seen;
    logic later_up;
  } word_flags_t;

  typedef enum int { PICK_UPPER, PICK_LOWER, PICK_DIGIT, PICK_ANY } char_pick_t;
  typedef enum int { WK_LOWER, WK_CAPITAL, WK_UPPER, WK_NUMBER, WK_MIXED, WK_NOISE } word_kind_t;

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [l2wcc_pkg::CHAR_W-1:0]   s_tdata  = '0;
  logic                           s_tlast  = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [l2wcc_pkg::TDATA_W-1:0]  m_tdata;

  logic [l2wcc_pkg::CLASS_W-1:0]  pending_classes [$];
  word_flags_t                    word_flags;
  int                             mismatches  = 0;
  int                             chars_sent  = 0;
  int                             cycle_count = 0;
  logic                           tx_burst    = 1'b0;
  logic                           rx_burst    = 1'b0;

  // cases that can be read off directly carry their class; the rest go through the tracker
  dir_row_t directed_rows [DIRECTED_N] = '{
    '{8'h61, 1'b1, 1'b1, l2wcc_pkg::CLASS_LOWER},   // one lower letter
    '{8'h5A, 1'b1, 1'b1, l2wcc_pkg::CLASS_CAP},     // one upper letter is capitalized
    '{8'h00, 1'b1, 1'b1, l2wcc_pkg::CLASS_UNDEF},   // zero byte is no class at all
    '{8'hFF, 1'b1, 1'b1, l2wcc_pkg::CLASS_UNDEF},   // all ones, no class either
    '{8'h2D, 1'b0, 1'b0, '0},            // leading minus number
    '{8'h31, 1'b0, 1'b0, '0},
    '{8'h2E, 1'b0, 1'b0, '0},
    '{8'h35, 1'b1, 1'b1, l2wcc_pkg::CLASS_NUM},
    '{8'h31, 1'b0, 1'b0, '0},            // second dot breaks the number
    '{8'h2E, 1'b0, 1'b0, '0},
    '{8'h2E, 1'b0, 1'b0, '0},
    '{8'h32, 1'b1, 1'b0, '0},
    '{8'h41, 1'b0, 1'b0, '0},            // plain upper word
    '{8'h42, 1'b1, 1'b1, l2wcc_pkg::CLASS_UPPER},
    '{8'hDF, 1'b1, 1'b0, '0},            // sharp s, both cases
    '{8'h61, 1'b0, 1'b0, '0},            // upper letter after the first
    '{8'h42, 1'b1, 1'b0, '0},
    '{8'hF7, 1'b1, 1'b0, '0},            // division sign counts as lower
    '{8'h31, 1'b0, 1'b0, '0},            // minus inside a number
    '{8'h2D, 1'b1, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, '0},
    '{8'hD7, 1'b1, 1'b0, '0},            // multiplication sign counts as lower
    '{8'hA7, 1'b0, 1'b0, '0},            // section sign counts as lower
    '{8'hFE, 1'b1, 1'b0, '0}
  };

  latin2_word_case_classifier_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [7:0] char_code
    .s_tlast  (s_tlast),    // last_char
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)     // [2:0] case_class, [7:3] zero
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // byte classes of ISO 8859-2
  // ---------------------------------------------------------------------------

  function automatic logic latin2_upper(input logic [l2wcc_pkg::CHAR_W-1:0] b);
    case (b)
      8'hA1, 8'hA3, 8'hA5, 8'hA6, 8'hA9, 8'hAA, 8'hAB, 8'hAC, 8'hAE, 8'hAF: return 1'b1;
      8'hD7: return 1'b0;   // multiplication sign sits inside the capital block
      default: return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'hC0 && b <= 8'hDF);
    endcase
  endfunction

  function automatic logic latin2_lower(input logic [l2wcc_pkg::CHAR_W-1:0] b);
    case (b)
      8'hB1, 8'hB3, 8'hB5, 8'hB6, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBE, 8'hBF: return 1'b1;
      8'hA7, 8'hD7, 8'hDF: return 1'b1;
      default: return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'hE0 && b <= 8'hFE);
    endcase
  endfunction

  function automatic logic latin2_digit(input logic [l2wcc_pkg::CHAR_W-1:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic word_flags_t fresh_word();
    word_flags_t f;
    f = '0;
    f.at_start = 1'b1;
    f.all_up   = 1'b1;
    f.numeric  = 1'b1;
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // word tracker: updates the flags per byte and queues the class of each word
  // ---------------------------------------------------------------------------

  task automatic track_word_byte(input logic [l2wcc_pkg::CHAR_W-1:0] b, input logic last,
                                 input logic typed,
                                 input logic [l2wcc_pkg::CLASS_W-1:0] typed_cls);
    logic                          first;
    logic                          up;
    logic [3:0]                    idx;
    logic [l2wcc_pkg::CLASS_W-1:0] cls;
    first = word_flags.at_start;
    up    = latin2_upper(b);
    if (first) word_flags.first_up = up;
    if (latin2_lower(b)) word_flags.all_up = 1'b0;
    if (up && !first) word_flags.later_up = 1'b1;
    if (latin2_digit(b)) begin
      word_flags.digit_seen = 1'b1;
    end else if (b == l2wcc_pkg::CHAR_DOT) begin
      // one dot is allowed in a number, a second one ends it
      if (word_flags.dot_seen) word_flags.numeric = 1'b0;
      else word_flags.dot_seen = 1'b1;
    end else if (b == l2wcc_pkg::CHAR_MINUS) begin
      // minus only as a sign in front
      if (!first) word_flags.numeric = 1'b0;
    end else begin
      word_flags.numeric = 1'b0;
    end
    word_flags.at_start = 1'b0;
    if (last) begin
      idx = {word_flags.first_up, word_flags.all_up, word_flags.digit_seen, word_flags.numeric};
      case (idx)
        4'b0000: cls = word_flags.later_up ? l2wcc_pkg::CLASS_MIXED : l2wcc_pkg::CLASS_LOWER;
        4'b1000: cls = word_flags.later_up ? l2wcc_pkg::CLASS_MIXED : l2wcc_pkg::CLASS_CAP;
        // a lone capital is capitalized
        4'b1100: cls = first ? l2wcc_pkg::CLASS_CAP : l2wcc_pkg::CLASS_UPPER;
        4'b0111: cls = l2wcc_pkg::CLASS_NUM;
        4'b0001, 4'b0010, 4'b0101, 4'b0110, 4'b1010, 4'b1110: cls = l2wcc_pkg::CLASS_MIXED;
        default: cls = l2wcc_pkg::CLASS_UNDEF;
      endcase
      pending_classes.push_back(typed ? typed_cls : cls);
      word_flags = fresh_word();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  // one request on the slave side, with a random gap in front
  task automatic offer_char(input logic [l2wcc_pkg::CHAR_W-1:0] code, input logic last,
                            input logic typed, input logic [l2wcc_pkg::CLASS_W-1:0] typed_cls);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    track_word_byte(code, last, typed, typed_cls);
    chars_sent++;
  endtask

  function automatic logic [l2wcc_pkg::CHAR_W-1:0] pick_char(input char_pick_t pick);
    logic [l2wcc_pkg::CHAR_W-1:0] b;
    case (pick)
      PICK_DIGIT: return 8'h30 + 8'($urandom_range(0, 9));
      PICK_UPPER: begin
        if ($urandom_range(0, 1)) return 8'h41 + 8'($urandom_range(0, 25));
        do b = 8'($urandom_range(0, 255)); while (!latin2_upper(b));
        return b;
      end
      PICK_LOWER: begin
        if ($urandom_range(0, 1)) return 8'h61 + 8'($urandom_range(0, 25));
        do b = 8'($urandom_range(0, 255)); while (!latin2_lower(b));
        return b;
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly well-formed words with random content, some mixed and some noise
  task automatic send_random_word();
    int                           roll;
    word_kind_t                   kind;
    int                           len;
    int                           i;
    logic                         dot_used;
    logic [l2wcc_pkg::CHAR_W-1:0] b;
    roll = $urandom_range(0, 99);
    if (roll < 18)      kind = WK_LOWER;
    else if (roll < 36) kind = WK_CAPITAL;
    else if (roll < 52) kind = WK_UPPER;
    else if (roll < 72) kind = WK_NUMBER;
    else if (roll < 86) kind = WK_MIXED;
    else                kind = WK_NOISE;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    dot_used = 1'b0;
    for (i = 0; i < len; i++) begin
      case (kind)
        WK_LOWER:   b = pick_char(PICK_LOWER);
        WK_CAPITAL: b = pick_char(i == 0 ? PICK_UPPER : PICK_LOWER);
        WK_UPPER:   b = pick_char(PICK_UPPER);
        WK_NUMBER: begin
          roll = $urandom_range(0, 99);
          if (i == 0 && roll < 25) begin
            b = l2wcc_pkg::CHAR_MINUS;
          end else if (roll < 15 && (!dot_used || roll < 2)) begin
            b = l2wcc_pkg::CHAR_DOT;   // now and then a second dot
            dot_used = 1'b1;
          end else if (roll == 99) begin
            b = l2wcc_pkg::CHAR_MINUS;  // stray minus inside
          end else begin
            b = pick_char(PICK_DIGIT);
          end
        end
        WK_MIXED: begin
          roll = $urandom_range(0, 9);
          if (roll < 3)      b = pick_char(PICK_UPPER);
          else if (roll < 6) b = pick_char(PICK_LOWER);
          else if (roll < 8) b = pick_char(PICK_DIGIT);
          else if (roll < 9) b = l2wcc_pkg::CHAR_DOT;
          else               b = l2wcc_pkg::CHAR_MINUS;
        end
        default: b = pick_char(PICK_ANY);
      endcase
      offer_char(b, i == len - 1, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls on m_tready, one draw per returned class
  // ---------------------------------------------------------------------------

  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // compare each returned class with the oldest prediction
  always @(posedge clk) begin
    logic [l2wcc_pkg::CLASS_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_classes.size() == 0) begin
        $display("%0t: unexpected class, expected none, got %0d", $time,
                 m_tdata[l2wcc_pkg::CLASS_W-1:0]);
        mismatches++;
      end else begin
        want = pending_classes.pop_front();
        if (m_tdata[l2wcc_pkg::CLASS_W-1:0] !== want) begin
          $display("%0t: case class mismatch, expected %0d, got %0d", $time, want,
                   m_tdata[l2wcc_pkg::CLASS_W-1:0]);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int i;
    int next_drain;
    word_flags = fresh_word();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (i = 0; i < DIRECTED_N; i++)
      offer_char(directed_rows[i].code, directed_rows[i].last,
                 directed_rows[i].typed, directed_rows[i].cls);

    // random words, with the sender holding off now and then until all classes are back
    next_drain = chars_sent + DRAIN_EVERY;
    while (chars_sent < DIRECTED_N + RANDOM_CHARS) begin
      send_random_word();
      if (chars_sent >= next_drain) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_classes.size() != 0);
        next_drain = chars_sent + DRAIN_EVERY;
      end
    end
    s_tvalid <= 1'b0;

    // wait for the tail, then give anything extra time to show
    while (pending_classes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
